@@ src/indexed_max_heap_assert.svh @@
// assertion macros for the indexed max-heap rtl
// used by the sequencer; no other dependencies
`ifndef INDEXED_MAX_HEAP_ASSERT_SVH
`define INDEXED_MAX_HEAP_ASSERT_SVH
`ifndef SYNTH
`define IMH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMH_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/imh_pkg.sv @@
// types, sizes and codes shared by the indexed max-heap modules
// no dependencies
`timescale 1ns / 1ps
package imh_pkg;
    localparam int HEAP_SLOTS = 1024;
    localparam int NODE_IDS   = 1024;
    localparam int SLOT_W     = $clog2(HEAP_SLOTS);
    localparam int NODE_W     = $clog2(NODE_IDS);
    localparam int CNT_W      = $clog2(HEAP_SLOTS + 1);
    localparam int CHILD_W    = SLOT_W + 2;
    localparam int KEY_W      = 32;

    typedef enum logic [2:0] {
        MODE_PUSH   = 3'd0,
        MODE_UPDATE = 3'd1,
        MODE_POP    = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_PEEK   = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_DISPATCH, S_POP_DATA, S_CK_DATA, S_RM_DATA,
        S_UP, S_UP_CMP, S_DN, S_DN_L, S_DN_R, S_PLACE, S_DONE
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
    } heap_entry_t;

    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } pos_entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        heap_entry_t       wdata;
        logic [SLOT_W-1:0] raddr;
    } heap_port_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        pos_entry_t        wdata;
        logic [NODE_W-1:0] raddr;
    } pos_port_t;

    typedef struct packed {
        status_t           status;
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
    } result_t;
endpackage

@@ src/imh_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ src/imh_ctrl.sv @@
// heap sequencer: operation decode, sift up and sift down over the two rams
// depends on imh_pkg and indexed_max_heap_assert.svh
`timescale 1ns / 1ps
`include "indexed_max_heap_assert.svh"
module imh_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  imh_pkg::mode_t              in_mode,
    input  logic [imh_pkg::NODE_W-1:0]  in_node,
    input  logic [imh_pkg::KEY_W-1:0]   in_key,
    output logic                        res_valid,
    input  logic                        res_ready,
    output imh_pkg::result_t            res,
    output imh_pkg::heap_port_t         hp,
    input  imh_pkg::heap_entry_t        h_rdata,
    output imh_pkg::pos_port_t          pp,
    input  imh_pkg::pos_entry_t         p_rdata
);
    imh_pkg::state_t                state_reg, state_next;
    imh_pkg::mode_t                 mode_reg, mode_next;
    logic [imh_pkg::NODE_W-1:0]     node_reg, node_next;
    logic [imh_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [imh_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [imh_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    imh_pkg::heap_entry_t           elem_reg, elem_next;
    imh_pkg::heap_entry_t           lchild_reg, lchild_next;
    logic                           try_down_reg, try_down_next;
    logic [imh_pkg::NODE_W-1:0]     idx_reg, idx_next;
    logic                           reply_reg, reply_next;
    imh_pkg::status_t               status_reg, status_next;
    imh_pkg::heap_entry_t           top_reg, top_next;

    logic [imh_pkg::SLOT_W-1:0]     par, par_par, last_slot, best_slot;
    logic [imh_pkg::CHILD_W-1:0]    cnt_ext, l_ext, r_ext, l2_ext, best_ext;
    logic                           left_gt, take_r, do_move;
    imh_pkg::heap_entry_t           child;

    assign par       = imh_pkg::SLOT_W'(slot_reg - 1'b1) >> 1;
    assign par_par   = imh_pkg::SLOT_W'(par - 1'b1) >> 1;
    assign last_slot = imh_pkg::SLOT_W'(cnt_reg - 1'b1);
    assign cnt_ext   = {{(imh_pkg::CHILD_W - imh_pkg::CNT_W){1'b0}}, cnt_reg};
    assign l_ext     = {1'b0, slot_reg, 1'b1};
    assign r_ext     = imh_pkg::CHILD_W'(l_ext + 1'b1);
    assign best_slot = best_ext[imh_pkg::SLOT_W-1:0];
    assign l2_ext    = {1'b0, best_slot, 1'b1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imh_pkg::S_CLR;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            reply_reg <= reply_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        node_reg     <= node_next;
        key_reg      <= key_next;
        slot_reg     <= slot_next;
        elem_reg     <= elem_next;
        lchild_reg   <= lchild_next;
        try_down_reg <= try_down_next;
        status_reg   <= status_next;
        top_reg      <= top_next;
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        node_next     = node_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        elem_next     = elem_reg;
        lchild_next   = lchild_reg;
        try_down_next = try_down_reg;
        idx_next      = idx_reg;
        reply_next    = reply_reg;
        status_next   = status_reg;
        top_next      = top_reg;
        hp            = '0;
        pp            = '0;
        in_ready      = 1'b0;
        left_gt       = 1'b0;
        take_r        = 1'b0;
        do_move       = 1'b0;
        best_ext      = l_ext;
        child         = h_rdata;

        case (state_reg)
            imh_pkg::S_IDLE: begin
                in_ready = 1'b1;
                pp.raddr = in_node;
                hp.raddr = '0;
                if (in_valid) begin
                    mode_next   = in_mode;
                    node_next   = in_node;
                    key_next    = in_key;
                    status_next = imh_pkg::ST_OK;
                    top_next    = '0;
                    case (in_mode)
                        imh_pkg::MODE_PUSH, imh_pkg::MODE_UPDATE,
                        imh_pkg::MODE_REMOVE: state_next = imh_pkg::S_DISPATCH;
                        imh_pkg::MODE_POP, imh_pkg::MODE_PEEK:
                            state_next = imh_pkg::S_POP_DATA;
                        imh_pkg::MODE_CLEAR: begin
                            cnt_next   = '0;
                            idx_next   = '0;
                            reply_next = 1'b1;
                            state_next = imh_pkg::S_CLR;
                        end
                        default: state_next = imh_pkg::S_DONE;
                    endcase
                end
            end
            // one position entry per cycle gets its present mark cleared
            imh_pkg::S_CLR: begin
                pp.we    = 1'b1;
                pp.waddr = idx_reg;
                idx_next = imh_pkg::NODE_W'(idx_reg + 1'b1);
                if (idx_reg == imh_pkg::NODE_W'(imh_pkg::NODE_IDS - 1)) begin
                    state_next = reply_reg ? imh_pkg::S_DONE : imh_pkg::S_IDLE;
                end
            end
            imh_pkg::S_DISPATCH: begin
                slot_next = p_rdata.slot;
                hp.raddr  = p_rdata.slot;
                elem_next = '{node: node_reg, key: key_reg};
                if (mode_reg == imh_pkg::MODE_REMOVE) begin
                    if (!p_rdata.present) begin
                        status_next = imh_pkg::ST_ABSENT;
                        state_next  = imh_pkg::S_DONE;
                    end else begin
                        pp.we    = 1'b1;
                        pp.waddr = node_reg;
                        cnt_next = imh_pkg::CNT_W'(cnt_reg - 1'b1);
                        hp.raddr = last_slot;
                        state_next = (p_rdata.slot == last_slot) ? imh_pkg::S_DONE
                                                                  : imh_pkg::S_RM_DATA;
                    end
                end else if (p_rdata.present) begin
                    state_next = imh_pkg::S_CK_DATA;
                end else if (mode_reg == imh_pkg::MODE_UPDATE) begin
                    status_next = imh_pkg::ST_ABSENT;
                    state_next  = imh_pkg::S_DONE;
                end else if (cnt_reg == imh_pkg::CNT_W'(imh_pkg::HEAP_SLOTS)) begin
                    status_next = imh_pkg::ST_FULL;
                    state_next  = imh_pkg::S_DONE;
                end else begin
                    slot_next     = cnt_reg[imh_pkg::SLOT_W-1:0];
                    cnt_next      = imh_pkg::CNT_W'(cnt_reg + 1'b1);
                    try_down_next = 1'b0;
                    state_next    = imh_pkg::S_UP;
                end
            end
            imh_pkg::S_POP_DATA: begin
                if (cnt_reg == '0) begin
                    status_next = imh_pkg::ST_EMPTY;
                    state_next  = imh_pkg::S_DONE;
                end else begin
                    top_next = h_rdata;
                    if (mode_reg == imh_pkg::MODE_PEEK) begin
                        state_next = imh_pkg::S_DONE;
                    end else begin
                        pp.we      = 1'b1;
                        pp.waddr   = h_rdata.node;
                        cnt_next   = imh_pkg::CNT_W'(cnt_reg - 1'b1);
                        slot_next  = '0;
                        hp.raddr   = last_slot;
                        state_next = (last_slot == '0) ? imh_pkg::S_DONE
                                                       : imh_pkg::S_RM_DATA;
                    end
                end
            end
            imh_pkg::S_CK_DATA: begin
                if ($signed(key_reg) > $signed(h_rdata.key)) begin
                    try_down_next = 1'b0;
                    state_next    = imh_pkg::S_UP;
                end else if ($signed(key_reg) < $signed(h_rdata.key)) begin
                    state_next = imh_pkg::S_DN;
                end else begin
                    state_next = imh_pkg::S_DONE;
                end
            end
            // the last entry fills the hole; it may have to go either way
            imh_pkg::S_RM_DATA: begin
                elem_next     = h_rdata;
                try_down_next = 1'b1;
                state_next    = (slot_reg == '0) ? imh_pkg::S_DN : imh_pkg::S_UP;
            end
            imh_pkg::S_UP: begin
                hp.raddr = par;
                state_next = (slot_reg == '0) ? imh_pkg::S_PLACE : imh_pkg::S_UP_CMP;
            end
            imh_pkg::S_UP_CMP: begin
                if ($signed(elem_reg.key) > $signed(h_rdata.key)) begin
                    hp.we         = 1'b1;
                    hp.waddr      = slot_reg;
                    hp.wdata      = h_rdata;
                    pp.we         = 1'b1;
                    pp.waddr      = h_rdata.node;
                    pp.wdata      = '{present: 1'b1, slot: slot_reg};
                    slot_next     = par;
                    try_down_next = 1'b0;
                    hp.raddr      = par_par;
                    state_next = (par == '0) ? imh_pkg::S_PLACE : imh_pkg::S_UP_CMP;
                end else begin
                    state_next = try_down_reg ? imh_pkg::S_DN : imh_pkg::S_PLACE;
                end
            end
            imh_pkg::S_DN: begin
                hp.raddr   = l_ext[imh_pkg::SLOT_W-1:0];
                state_next = (l_ext < cnt_ext) ? imh_pkg::S_DN_L : imh_pkg::S_PLACE;
            end
            imh_pkg::S_DN_L, imh_pkg::S_DN_R: begin
                if (state_reg == imh_pkg::S_DN_L) begin
                    lchild_next = h_rdata;
                    left_gt     = $signed(h_rdata.key) > $signed(elem_reg.key);
                    child       = h_rdata;
                    do_move     = left_gt && !(r_ext < cnt_ext);
                end else begin
                    left_gt = $signed(lchild_reg.key) > $signed(elem_reg.key);
                    take_r  = $signed(h_rdata.key) > (left_gt ? $signed(lchild_reg.key)
                                                              : $signed(elem_reg.key));
                    child    = take_r ? h_rdata : lchild_reg;
                    best_ext = take_r ? r_ext : l_ext;
                    do_move  = take_r || left_gt;
                end
                if (state_reg == imh_pkg::S_DN_L && r_ext < cnt_ext) begin
                    hp.raddr   = r_ext[imh_pkg::SLOT_W-1:0];
                    state_next = imh_pkg::S_DN_R;
                end else if (do_move) begin
                    hp.we      = 1'b1;
                    hp.waddr   = slot_reg;
                    hp.wdata   = child;
                    pp.we      = 1'b1;
                    pp.waddr   = child.node;
                    pp.wdata   = '{present: 1'b1, slot: slot_reg};
                    slot_next  = best_slot;
                    hp.raddr   = l2_ext[imh_pkg::SLOT_W-1:0];
                    state_next = (l2_ext < cnt_ext) ? imh_pkg::S_DN_L : imh_pkg::S_PLACE;
                end else begin
                    state_next = imh_pkg::S_PLACE;
                end
            end
            imh_pkg::S_PLACE: begin
                hp.we      = 1'b1;
                hp.waddr   = slot_reg;
                hp.wdata   = elem_reg;
                pp.we      = 1'b1;
                pp.waddr   = elem_reg.node;
                pp.wdata   = '{present: 1'b1, slot: slot_reg};
                state_next = imh_pkg::S_DONE;
            end
            imh_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = imh_pkg::S_IDLE;
                end
            end
            default: state_next = imh_pkg::S_IDLE;
        endcase
    end

    assign res_valid = (state_reg == imh_pkg::S_DONE);
    assign res       = '{status: status_reg, node: top_reg.node, key: top_reg.key,
                         count: cnt_reg};

    `IMH_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= imh_pkg::CNT_W'(imh_pkg::HEAP_SLOTS),
        "heap count beyond capacity")
    `IMH_ASSERT(a_idle_quiet, aclk, aresetn, in_ready |-> !hp.we && !pp.we,
        "memory write while waiting for an item")
    `IMH_ASSERT(a_clr_empty, aclk, aresetn, state_reg == imh_pkg::S_CLR |-> cnt_reg == '0,
        "present marks swept while heap not empty")
    `IMH_ASSERT(a_err_zero, aclk, aresetn,
        res_valid && status_reg != imh_pkg::ST_OK |-> top_reg == '0,
        "error result carries a node")
endmodule

@@ src/indexed_max_heap.sv @@
// Indexed binary max-heap with a node-to-slot position map.
// Sift up reads one parent per level; sift down reads the left and then the right
// child per level through the single read port of the 1024-slot heap ram.
// After reset a sweep clears the present marks of all position entries; s_tready stays low.
// depends on imh_pkg, imh_ram and imh_ctrl
`timescale 1ns / 1ps
module indexed_max_heap (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // node_id[9:0], key_value[41:10], zero pad
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_node[9:0], out_key[41:10], fill_count[52:42], pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    imh_pkg::heap_port_t  hp;
    imh_pkg::pos_port_t   pp;
    imh_pkg::heap_entry_t h_rdata;
    imh_pkg::pos_entry_t  p_rdata;
    imh_pkg::result_t     res;
    logic                 res_valid, res_ready;
    logic                 m_tvalid_reg;
    imh_pkg::result_t     m_res_reg;

    imh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (imh_pkg::mode_t'(s_tuser)),
        .in_node   (s_tdata[9:0]),
        .in_key    (s_tdata[41:10]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .hp        (hp),
        .h_rdata   (h_rdata),
        .pp        (pp),
        .p_rdata   (p_rdata)
    );

    imh_ram #(
        .WIDTH ($bits(imh_pkg::heap_entry_t)),
        .DEPTH (imh_pkg::HEAP_SLOTS)
    ) u_heap_ram (
        .aclk  (aclk),
        .we    (hp.we),
        .waddr (hp.waddr),
        .wdata (hp.wdata),
        .raddr (hp.raddr),
        .rdata (h_rdata)
    );

    imh_ram #(
        .WIDTH ($bits(imh_pkg::pos_entry_t)),
        .DEPTH (imh_pkg::NODE_IDS)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (pp.we),
        .waddr (pp.waddr),
        .wdata (pp.wdata),
        .raddr (pp.raddr),
        .rdata (p_rdata)
    );

    // output register frees the sequencer while the item waits downstream
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {3'b000, m_res_reg.count, m_res_reg.key, m_res_reg.node};
endmodule
